@@ sv/font_glyph_address_gen_assert.svh @@
// ----------------------------------------------------------------------------
// Font glyph address generator assertion macros
// Shared property wrappers for the checker of the font glyph address block.
// ----------------------------------------------------------------------------
`ifndef FONT_GLYPH_ADDRESS_GEN_ASSERT_SVH
`define FONT_GLYPH_ADDRESS_GEN_ASSERT_SVH

// Property checked at every clock edge outside of reset.
`define FGAG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define FGAG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/fgag_pkg.sv @@
// ----------------------------------------------------------------------------
// Font glyph address generator package
// Transaction types, address map constants and size codes.
// ----------------------------------------------------------------------------
package fgag_pkg;

   localparam logic [31:0] BaseAddr    = 32'h00F0_0000;
   localparam logic [31:0] Half16Base  = 32'h0003_A800;
   localparam logic [31:0] Half24Base  = 32'h0003_D000;
   localparam logic [31:0] Full24Base  = 32'h0004_0000;
   localparam logic [6:0]  CellsPerRow = 7'd94;
   localparam logic [7:0]  JisFirst    = 8'h21;
   localparam logic [7:0]  JisLast     = 8'h7E;
   localparam logic [7:0]  JisUpperRow = 8'h30;
   localparam logic [31:0] SizeCode24  = 32'd12;
   localparam logic [31:0] SizeCode12h = 32'd6;

   localparam logic [1:0] RowBytesHalf16 = 2'd0;
   localparam logic [1:0] RowBytesFull16 = 2'd1;
   localparam logic [1:0] RowBytesHalf24 = 2'd1;
   localparam logic [1:0] RowBytesFull24 = 2'd2;
   localparam logic [4:0] Rows12         = 5'd11;
   localparam logic [4:0] Rows16         = 5'd15;
   localparam logic [4:0] Rows24         = 5'd23;

   typedef struct packed {
      logic [15:0] char_code;
      logic [31:0] font_size;
   } req_type;

   typedef struct packed {
      logic [31:0] rom_address;
      logic [1:0]  row_bytes_minus_one;
      logic [4:0]  rows_minus_one;
   } rsp_type;

   // Result of code classification, first pipeline stage.
   typedef struct packed {
      logic       full_width;
      logic       size24;
      logic       size12h;
      logic [6:0] row_idx;
      logic [8:0] cell_off;   // signed cell offset from the first cell
      logic [7:0] low_byte;
   } map_type;

   // Linear glyph index, second pipeline stage.
   typedef struct packed {
      logic        full_width;
      logic        size24;
      logic        size12h;
      logic [14:0] lin;       // signed linear index
      logic [7:0]  low_byte;
   } lin_type;

endpackage

@@ sv/fgag_code_map.sv @@
// ----------------------------------------------------------------------------
// Font glyph code map
// Converts Shift-JIS lead and trail bytes to a JIS row and cell, picks the
// full-width or half-width area and decodes the size code.
// ----------------------------------------------------------------------------
module fgag_code_map
   import fgag_pkg::*;
(
   input  req_type req,
   output map_type map
);

   logic [7:0] hi;
   logic [7:0] lo;
   logic       lead;
   logic [5:0] sjis_row;
   logic [8:0] trail_off;
   logic       odd_row;
   logic [8:0] sjis_cell;
   logic [7:0] jis_row;
   logic [8:0] cell_off;

   assign hi = req.char_code[15:8];
   assign lo = req.char_code[7:0];

   always_comb begin
      lead = ((hi >= 8'h81) && (hi <= 8'h9F)) || ((hi >= 8'hE0) && (hi <= 8'hEF));
      sjis_row = (hi >= 8'hE0) ? 6'(hi - 8'hC1) : 6'(hi - 8'h81);
      trail_off = (lo >= 8'h80) ? ({1'b0, lo} - 9'h041) : ({1'b0, lo} - 9'h040);
      // A negative offset counts as a huge unsigned value, so it also wraps
      // into the second row of the pair.
      odd_row = trail_off[8] || (trail_off >= {2'b00, CellsPerRow});
      sjis_cell = odd_row ? (trail_off - {2'b00, CellsPerRow}) : trail_off;

      if (lead) begin
         jis_row  = {1'b0, sjis_row, odd_row} + JisFirst;
         cell_off = sjis_cell;
      end else begin
         jis_row  = hi;
         cell_off = {1'b0, lo} - {1'b0, JisFirst};
      end

      map.full_width = (jis_row >= JisFirst) && (jis_row <= JisLast);
      map.row_idx    = (jis_row >= JisUpperRow) ? 7'(jis_row - 8'h28)
                                                : 7'(jis_row - JisFirst);
      map.cell_off   = cell_off;
      map.low_byte   = lo;
      map.size24     = (req.font_size == SizeCode24);
      map.size12h    = (req.font_size == SizeCode12h);
   end

endmodule

@@ sv/font_glyph_address_gen.sv @@
// ----------------------------------------------------------------------------
// Font glyph address generator
// Maps a character code and a size code to a font ROM glyph address and
// the glyph's geometry.
//
//   Channel  Direction  Payload
//   req_     in         char_code, font_size
//   rsp_     out        rom_address, row_bytes_minus_one, rows_minus_one
//
// Three register stages: code map, linear index multiply, address scale.
// A transaction passes through the stages in order and one may enter every
// cycle unless rsp_ready stalls; the row-times-cells multiply sets stage depth.
// Synchronous reset clears the stage valid bits only.
// A stall on rsp_ready holds each stage; an empty stage still fills.
// ----------------------------------------------------------------------------
module font_glyph_address_gen
   import fgag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   map_type map;
   map_type s1_ff;
   logic    s1_valid_ff, s1_valid_in;
   lin_type s2_ff, s2_in;
   logic    s2_valid_ff, s2_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    s1_ready, s2_ready, s3_ready;
   logic [31:0] lin_ext;
   logic [31:0] lo_ext;
   logic [31:0] offset;

   fgag_code_map u_map (
      .req (req_payload),
      .map (map)
   );

   assign s3_ready  = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign s1_valid_in  = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = s3_ready ? s2_valid_ff : rsp_valid_ff;

   always_comb begin
      s2_in.full_width = s1_ff.full_width;
      s2_in.size24     = s1_ff.size24;
      s2_in.size12h    = s1_ff.size12h;
      s2_in.low_byte   = s1_ff.low_byte;
      s2_in.lin        = 15'(s1_ff.row_idx) * 15'(CellsPerRow)
                       + {{6{s1_ff.cell_off[8]}}, s1_ff.cell_off};
   end

   always_comb begin
      lin_ext = {{17{s2_ff.lin[14]}}, s2_ff.lin};
      lo_ext  = {24'd0, s2_ff.low_byte};
      if (s2_ff.full_width) begin
         offset = s2_ff.size24 ? ((lin_ext << 6) + (lin_ext << 3) + Full24Base)
                               : (lin_ext << 5);
         rsp_in.row_bytes_minus_one = s2_ff.size24 ? RowBytesFull24 : RowBytesFull16;
      end else begin
         offset = s2_ff.size24 ? ((lo_ext << 5) + (lo_ext << 4) + Half24Base)
                               : ((lo_ext << 4) + Half16Base);
         rsp_in.row_bytes_minus_one = s2_ff.size24 ? RowBytesHalf24 : RowBytesHalf16;
      end
      rsp_in.rom_address = BaseAddr + offset;
      if (s2_ff.size24) begin
         rsp_in.rows_minus_one = Rows24;
      end else if (s2_ff.size12h) begin
         rsp_in.rows_minus_one = Rows12;
      end else begin
         rsp_in.rows_minus_one = Rows16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_ff <= map;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
      if (s3_ready && s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ sv/fgag_checker.sv @@
// ----------------------------------------------------------------------------
// Font glyph address generator checker
// Port-level assertions on both channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "font_glyph_address_gen_assert.svh"

module fgag_checker
   import fgag_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   `FGAG_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

   `FGAG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled transaction changed")

   `FGAG_ASSERT(a_rows_legal, clock, reset, rsp_valid |-> rsp_payload.rows_minus_one == Rows12 || rsp_payload.rows_minus_one == Rows16 || rsp_payload.rows_minus_one == Rows24, "illegal glyph height")

   `FGAG_ASSERT(a_wide_rows_match, clock, reset, rsp_valid && rsp_payload.row_bytes_minus_one == RowBytesFull24 |-> rsp_payload.rows_minus_one == Rows24, "24-dot width without 24-dot height")

   // With the output register empty, the input side must never be held off.
   `FGAG_ASSERT(a_no_false_stall, clock, reset, !rsp_valid && !req_ready |-> 1'b0, "input stalled with empty output")

endmodule

bind font_glyph_address_gen fgag_checker u_fgag_checker (.*);

@@ dv/font_glyph_address_gen_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Font glyph address generator checker
// Watches both channels of the glyph address block. Every accepted request
// is turned into the expected glyph address and geometry. Every accepted
// response is compared field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module font_glyph_address_gen_checker
   import fgag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      error_count,
   output int      outstanding
);

   // Shift-JIS lead and trail byte boundaries.
   localparam logic [31:0] LeadLowFirst   = 32'h81;
   localparam logic [31:0] LeadLowLast    = 32'h9F;
   localparam logic [31:0] LeadHighFirst  = 32'hE0;
   localparam logic [31:0] LeadHighLast   = 32'hEF;
   localparam logic [31:0] LeadHighOffset = 32'hC1;
   localparam logic [31:0] TrailSplit     = 32'h80;
   localparam logic [31:0] TrailLowOffset = 32'h40;
   localparam logic [31:0] TrailHighOffset = 32'h41;
   localparam logic [31:0] UpperRowFirst  = 32'd8;

   rsp_type pending_glyphs[$];
   int      mismatches = 0;

   // All arithmetic is done on 32-bit vectors so that every underflow wraps
   // exactly as the address map expects.
   function automatic rsp_type glyph_lookup(input req_type item);
      logic [31:0] row;
      logic [31:0] cell_val;
      logic [31:0] row_idx;
      logic [31:0] lin;
      rsp_type     glyph;
      row      = {24'd0, item.char_code[15:8]};
      cell_val = {24'd0, item.char_code[7:0]};
      if ((row >= LeadLowFirst && row <= LeadLowLast) ||
          (row >= LeadHighFirst && row <= LeadHighLast)) begin
         row      = (row >= LeadHighFirst) ? row - LeadHighOffset : row - LeadLowFirst;
         cell_val = (cell_val >= TrailSplit) ? cell_val - TrailHighOffset
                                             : cell_val - TrailLowOffset;
         row      = row * 32'd2;
         if (cell_val >= 32'(CellsPerRow)) begin
            cell_val = cell_val - 32'(CellsPerRow);
            row      = row + 32'd1;
         end
         row      = row + 32'(JisFirst);
         cell_val = cell_val + 32'(JisFirst);
      end
      if (row >= 32'(JisFirst) && row <= 32'(JisLast)) begin
         // Rows from the upper row on continue at linear row eight.
         if (row >= 32'(JisUpperRow)) begin
            row_idx = row - 32'(JisUpperRow) + UpperRowFirst;
         end else begin
            row_idx = row - 32'(JisFirst);
         end
         lin = row_idx * 32'(CellsPerRow) + (cell_val - 32'(JisFirst));
         if (item.font_size == SizeCode24) begin
            glyph.rom_address         = BaseAddr + (lin * 32'd72 + Full24Base);
            glyph.row_bytes_minus_one = RowBytesFull24;
            glyph.rows_minus_one      = Rows24;
         end else begin
            glyph.rom_address         = BaseAddr + lin * 32'd32;
            glyph.row_bytes_minus_one = RowBytesFull16;
            glyph.rows_minus_one      = (item.font_size == SizeCode12h) ? Rows12 : Rows16;
         end
      end else begin
         if (item.font_size == SizeCode24) begin
            glyph.rom_address         = BaseAddr + (cell_val * 32'd48 + Half24Base);
            glyph.row_bytes_minus_one = RowBytesHalf24;
            glyph.rows_minus_one      = Rows24;
         end else begin
            glyph.rom_address         = BaseAddr + (cell_val * 32'd16 + Half16Base);
            glyph.row_bytes_minus_one = RowBytesHalf16;
            glyph.rows_minus_one      = (item.font_size == SizeCode12h) ? Rows12 : Rows16;
         end
      end
      return glyph;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_glyphs.push_back(glyph_lookup(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_glyphs.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatches++;
            end else begin
               want = pending_glyphs.pop_front();
               if (rsp_payload.rom_address !== want.rom_address) begin
                  $error("rom_address: expected %h, got %h",
                         want.rom_address, rsp_payload.rom_address);
                  mismatches++;
               end
               if (rsp_payload.row_bytes_minus_one !== want.row_bytes_minus_one) begin
                  $error("row_bytes_minus_one: expected %0d, got %0d",
                         want.row_bytes_minus_one, rsp_payload.row_bytes_minus_one);
                  mismatches++;
               end
               if (rsp_payload.rows_minus_one !== want.rows_minus_one) begin
                  $error("rows_minus_one: expected %0d, got %0d",
                         want.rows_minus_one, rsp_payload.rows_minus_one);
                  mismatches++;
               end
            end
         end
      end
      // Published through nonblocking assignments so that readers never race the update.
      outstanding <= pending_glyphs.size();
      error_count <= mismatches;
   end

endmodule

@@ dv/font_glyph_address_gen_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Font glyph address generator testbench
// Drives directed character codes around the Shift-JIS, JIS row and cell
// boundaries for every size class, then random codes with random idles on
// both channels. A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module font_glyph_address_gen_tb;
   import fgag_pkg::*;

   localparam int RandomChars = 1250;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    calm = 1'b0;
   int      error_count;
   int      outstanding;

   font_glyph_address_gen uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   font_glyph_address_gen_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 29);
   end

   task automatic send_char(input logic [15:0] code, input logic [31:0] size);
      if (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{char_code: code, font_size: size};
      do @(posedge clock); while (!req_ready);
   endtask

   // Mostly Shift-JIS and JIS codes so the full-width path is well exercised.
   task automatic send_random_char();
      logic [15:0] code;
      logic [31:0] size;
      int          pick;
      pick = $urandom_range(9);
      code = 16'($urandom);
      if (pick < 4) begin
         code[15:8] = $urandom_range(1) ? 8'($urandom_range(8'h9F, 8'h81))
                                        : 8'($urandom_range(8'hEF, 8'hE0));
      end else if (pick < 7) begin
         code[15:8] = 8'($urandom_range(JisLast, JisFirst));
         if ($urandom_range(3) != 0) begin
            code[7:0] = 8'($urandom_range(JisLast, JisFirst));
         end
      end
      case ($urandom_range(3))
         0: size = SizeCode12h;
         1: size = SizeCode24;
         2: size = $urandom;
         default: size = $urandom_range(31);
      endcase
      send_char(code, size);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_char(16'h0000, 32'd0);
      send_char(16'hFFFF, '1);
      send_char(16'h8140, SizeCode24);
      send_char(16'h81FF, SizeCode12h);
      send_char(16'h8100, 32'd16);        // trail below the Shift-JIS range
      send_char(16'h813F, SizeCode24);
      send_char(16'h817E, 32'd0);
      send_char(16'h817F, SizeCode24);
      send_char(16'h8180, SizeCode12h);
      send_char(16'h819E, 32'd0);         // last cell of the even row
      send_char(16'h819F, SizeCode24);    // first cell of the odd row
      send_char(16'h9FFC, 32'd0);
      send_char(16'hE040, SizeCode24);
      send_char(16'hEFFC, SizeCode12h);
      send_char(16'h8041, SizeCode24);
      send_char(16'hA0C8, 32'd0);
      send_char(16'hDF7F, SizeCode12h);
      send_char(16'hF0FF, SizeCode24);
      send_char(16'h2121, 32'd0);
      send_char(16'h2F7E, SizeCode24);
      send_char(16'h3021, SizeCode12h);
      send_char(16'h7E7E, SizeCode24);
      send_char(16'h7F41, 32'd0);
      send_char(16'h2000, SizeCode24);
      send_char(16'h2100, '1);            // cell below the first JIS cell
      send_char(16'h30FF, SizeCode24);

      for (int i = 0; i < RandomChars; i++) begin
         if (i == 300) begin
            calm <= 1'b1;
         end else if (i == 500) begin
            calm <= 1'b0;
         end else if (i == 700) begin
            // Let the pipeline drain completely before continuing.
            req_valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
         end
         send_random_char();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("font_glyph_address_gen_tb: clean");
      end else begin
         $display("font_glyph_address_gen_tb: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("font_glyph_address_gen_tb: errors");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/fgag_pkg.sv
sv/fgag_code_map.sv
sv/font_glyph_address_gen.sv
sv/fgag_checker.sv
dv/font_glyph_address_gen_checker.sv
dv/font_glyph_address_gen_tb.sv
